### hdl/slat_pkg.sv
package slat_pkg;

  localparam int MAX_IN_BITS  = 8;
  localparam int MAX_OUT_BITS = 8;
  localparam int STORE_DEPTH  = 1 << MAX_IN_BITS;
  localparam int ADDR_W       = 8;
  localparam int DATA_W       = 8;
  localparam int COUNT_W      = 9;
  localparam int WIDTH_W      = 4;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic REG_IN_WIDTH  = 1'b0;
  localparam logic REG_OUT_WIDTH = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] entry_index;
    logic [DATA_W-1:0] entry_value;
    logic [ADDR_W-1:0] in_mask;
    logic [DATA_W-1:0] out_mask;
  } in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] zero_count;
    logic [ADDR_W-1:0]  echo_in_mask;
    logic [DATA_W-1:0]  echo_out_mask;
  } out_t;

  // load: arg_a = masked entry index, arg_b = value
  // query: arg_a = in_mask, arg_b = out_mask (raw, echoed back)
  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] arg_a;
    logic [DATA_W-1:0] arg_b;
  } op_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] in_width;
    logic [WIDTH_W-1:0] out_width;
  } cfg_t;

  typedef struct packed {
    logic idle;
    logic fin;
  } bk_status_t;

  function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] w,
                                                     input logic [WIDTH_W-1:0] hi);
    logic [WIDTH_W-1:0] r;
    if (w == '0) begin
      r = WIDTH_W'(1);
    end else if (w > hi) begin
      r = hi;
    end else begin
      r = w;
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] low_mask(input logic [WIDTH_W-1:0] w);
    logic [DATA_W:0] m;
    m = ((DATA_W+1)'(1) << w) - (DATA_W+1)'(1);
    return m[DATA_W-1:0];
  endfunction

endpackage

### hdl/slat_ram.sv
module slat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/slat_front.sv
module slat_front (
  input  logic           clk,
  input  logic           rst,
  input  slat_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  slat_pkg::in_t  in_data,
  output logic           op_valid,
  input  logic           op_ready,
  output slat_pkg::op_t  op_data
);
  import slat_pkg::*;

  logic hold_valid;
  logic hold_valid_next;
  op_t  hold;
  op_t  classified;
  logic accept;

  assign in_ready = !hold_valid || op_ready;
  assign accept   = in_valid && in_ready;
  assign op_valid = hold_valid;
  assign op_data  = hold;

  always_comb begin
    classified.kind = in_data.kind;
    if (in_data.kind == KIND_LOAD) begin
      classified.arg_a = in_data.entry_index & low_mask(cfg.in_width);
      classified.arg_b = in_data.entry_value;
    end else begin
      classified.arg_a = in_data.in_mask;
      classified.arg_b = in_data.out_mask;
    end
  end

  always_comb begin
    hold_valid_next = hold_valid;
    if (accept) begin
      hold_valid_next = 1'b1;
    end else if (op_ready) begin
      hold_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
    end
    if (accept) begin
      hold <= classified;
    end
  end

endmodule

### hdl/slat_queue.sv
module slat_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  slat_pkg::op_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output slat_pkg::op_t pop_data
);
  import slat_pkg::*;

  op_t        slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

### hdl/slat_back.sv
module slat_back (
  input  logic                 clk,
  input  logic                 rst,
  input  slat_pkg::cfg_t       cfg,
  input  logic                 op_valid,
  output logic                 op_ready,
  input  slat_pkg::op_t        op_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output slat_pkg::out_t       out_data,
  output slat_pkg::bk_status_t status
);
  import slat_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [ADDR_W:0]     x;
  logic [ADDR_W:0]     n_items;
  logic                issue;
  logic                rd_valid;
  logic [ADDR_W-1:0]   rd_x;
  logic [DATA_W-1:0]   rdata;
  logic [COUNT_W-1:0]  count;
  logic [ADDR_W-1:0]   mask_a;
  logic [DATA_W-1:0]   mask_b;
  logic [ADDR_W-1:0]   eff_a;
  logic [DATA_W-1:0]   eff_b;
  logic                ram_we;
  logic                start;
  logic                hit;
  logic                emit;

  assign n_items  = (ADDR_W+1)'((ADDR_W+1)'(1) << cfg.in_width);
  assign eff_a    = mask_a & low_mask(cfg.in_width);
  assign eff_b    = mask_b & low_mask(cfg.out_width);
  assign op_ready = (state == ST_IDLE);
  assign ram_we   = op_valid && op_ready && (op_data.kind == KIND_LOAD);
  assign start    = op_valid && op_ready && (op_data.kind == KIND_QUERY);
  assign issue    = (state == ST_SCAN) && (x != n_items);
  assign hit      = rd_valid && !((^(rd_x & eff_a)) ^ (^(rdata & eff_b)));
  assign emit     = (state == ST_FIN) && (!out_valid || out_ready);

  assign status.idle = (state == ST_IDLE);
  assign status.fin  = (state == ST_FIN);

  slat_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(op_data.arg_a),
    .wdata(op_data.arg_b),
    .raddr(x[ADDR_W-1:0]),
    .rdata(rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!issue && !rd_valid) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (emit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= issue;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    rd_x <= x[ADDR_W-1:0];
    if (start) begin
      x      <= '0;
      count  <= '0;
      mask_a <= op_data.arg_a;
      mask_b <= op_data.arg_b;
    end else begin
      if (issue) begin
        x <= x + (ADDR_W+1)'(1);
      end
      if (hit) begin
        count <= count + COUNT_W'(1);
      end
    end
    if (emit) begin
      out_data.zero_count    <= count;
      out_data.echo_in_mask  <= mask_a;
      out_data.echo_out_mask <= mask_b;
    end
  end

endmodule

### hdl/sbox_linear_approximation_table.sv
// S-box linear approximation table cell counter.
// in channel (in_valid/in_ready/in_data): kind 0 loads one S-box entry,
// kind 1 queries one table cell with in_mask/out_mask. Loads give no result.
// out channel (out_valid/out_ready/out_data): one result per query carrying
// the zero-parity count and both masks as given.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 in_width,
// index 1 out_width; always ready, write only while idle.
// A front register and a two-entry queue feed the executor, so requests keep
// being taken while a query runs, until the queue and front register fill.
// Load: written to the store when the executor takes it. Query: 2^in_width store
// reads, one per cycle through the single read port of the store; the executor
// takes no new request until the query's result has been emitted.
// Reset empties the queue and result register and sets both widths to 8;
// the store keeps its contents and must be loaded before queries read it.
// A stalled result holds the executor at the end of the next query; loads
// behind that query go through once the stalled result is taken.
module sbox_linear_approximation_table (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  slat_pkg::in_t       in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output slat_pkg::out_t      out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [3:0]          cfg_data
);
  import slat_pkg::*;

  logic [WIDTH_W-1:0] in_width;
  logic [WIDTH_W-1:0] out_width;
  cfg_t               cfg;
  logic               f_valid;
  logic               f_ready;
  op_t                f_data;
  logic               q_valid;
  logic               q_ready;
  op_t                q_data;
  bk_status_t         bk_status;

  assign cfg_ready     = 1'b1;
  assign cfg.in_width  = clamp_width(in_width, WIDTH_W'(MAX_IN_BITS));
  assign cfg.out_width = clamp_width(out_width, WIDTH_W'(MAX_OUT_BITS));

  always_ff @(posedge clk) begin
    if (rst) begin
      in_width  <= WIDTH_W'(8);
      out_width <= WIDTH_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IN_WIDTH:  in_width  <= cfg_data;
        REG_OUT_WIDTH: out_width <= cfg_data;
        default: ;
      endcase
    end
  end

  slat_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data (in_data),
    .op_valid(f_valid),
    .op_ready(f_ready),
    .op_data (f_data)
  );

  slat_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_data (f_data),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_data  (q_data)
  );

  slat_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .op_valid (q_valid),
    .op_ready (q_ready),
    .op_data  (q_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .status   (bk_status)
  );

`ifndef SYNTHESIS
  a_reset_clears_out: assert property (@(posedge clk) $past(rst) && !rst |-> !out_valid)
    else $error("result valid right after reset");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(bk_status.fin))
    else $error("result raised outside the finish step");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.zero_count <= COUNT_W'(STORE_DEPTH))
    else $error("zero count above store depth");

  a_fin_not_idle: assert property (@(posedge clk) disable iff (rst)
    !(bk_status.fin && bk_status.idle))
    else $error("executor idle and finishing at once");
`endif

endmodule
